// ===== src/amte_pkg.sv =====
`default_nettype none

package amte_pkg;

    localparam int OUT_WIDTH       = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int S_TDATA_WIDTH   = 16;
    localparam int M_TDATA_WIDTH   = 40;

    typedef enum logic [1:0] {
        COL_ALIGNED   = 2'd0,
        COL_INSERTION = 2'd1,
        COL_DELETION  = 2'd2,
        COL_SOFT_CLIP = 2'd3
    } column_kind_t;

    typedef enum logic [1:0] {
        TOK_MISMATCH  = 2'd0,
        TOK_DEL_START = 2'd1,
        TOK_DEL_BASE  = 2'd2,
        TOK_CLOSE_RUN = 2'd3
    } token_kind_t;

    // One queued item: which tokens it causes and the values they carry.
    typedef struct packed {
        logic                   has_lead;
        logic                   lead_is_del;
        logic                   has_del_base;
        logic                   has_close;
        logic [1:0]             base;
        logic [OUT_WIDTH-1:0]   run_pre;
        logic [OUT_WIDTH-1:0]   run_post;
        logic [OUT_WIDTH-1:0]   edit;
    } job_t;

endpackage

`default_nettype wire

// ===== src/amte_front.sv =====
`default_nettype none

module amte_front #(
    parameter int COUNT_WIDTH = amte_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire logic [1:0]          column_kind,
    input  wire logic                first_of_op,
    input  wire logic [1:0]          ref_base,
    input  wire logic [2:0]          read_base,
    input  wire logic                inside_reference,
    input  wire logic                last_column,
    output amte_pkg::job_t           job,
    output logic                     job_push
);
    import amte_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] match_run_reg, match_run_next;
    logic [COUNT_WIDTH-1:0] edit_count_reg, edit_count_next;
    logic [COUNT_WIDTH-1:0] run_mid, edit_new;
    logic [COUNT_WIDTH-1:0] run_inc, edit_inc;
    logic                   aligned_in, mismatch, edit_step;
    logic                   has_lead, has_del_base;
    logic [OUT_WIDTH-1:0]   run_pre_out, run_post_out, edit_out;

    assign run_inc  = (match_run_reg == COUNT_MAX) ? COUNT_MAX : match_run_reg + 1'b1;
    assign edit_inc = (edit_count_reg == COUNT_MAX) ? COUNT_MAX : edit_count_reg + 1'b1;

    assign aligned_in   = (column_kind == COL_ALIGNED) && inside_reference;
    assign mismatch     = read_base != {1'b0, ref_base};
    assign edit_step    = (aligned_in && mismatch) || (column_kind == COL_INSERTION)
                          || (column_kind == COL_DELETION);
    assign edit_new     = edit_step ? edit_inc : edit_count_reg;
    assign has_lead     = (aligned_in && mismatch) || ((column_kind == COL_DELETION) && first_of_op);
    assign has_del_base = (column_kind == COL_DELETION) && inside_reference;

    always_comb begin
        run_mid = match_run_reg;
        if (aligned_in) begin
            run_mid = mismatch ? '0 : run_inc;
        end else if ((column_kind == COL_DELETION) && first_of_op) begin
            run_mid = '0;
        end
    end

    generate
        if (COUNT_WIDTH > OUT_WIDTH) begin : g_clamp
            assign run_pre_out  = (|match_run_reg[COUNT_WIDTH-1:OUT_WIDTH]) ?
                                  {OUT_WIDTH{1'b1}} : match_run_reg[OUT_WIDTH-1:0];
            assign run_post_out = (|run_mid[COUNT_WIDTH-1:OUT_WIDTH]) ?
                                  {OUT_WIDTH{1'b1}} : run_mid[OUT_WIDTH-1:0];
            assign edit_out     = (|edit_new[COUNT_WIDTH-1:OUT_WIDTH]) ?
                                  {OUT_WIDTH{1'b1}} : edit_new[OUT_WIDTH-1:0];
        end else begin : g_extend
            assign run_pre_out  = OUT_WIDTH'(match_run_reg);
            assign run_post_out = OUT_WIDTH'(run_mid);
            assign edit_out     = OUT_WIDTH'(edit_new);
        end
    endgenerate

    always_comb begin
        job.has_lead     = has_lead;
        job.lead_is_del  = column_kind == COL_DELETION;
        job.has_del_base = has_del_base;
        job.has_close    = last_column;
        job.base         = ref_base;
        job.run_pre      = run_pre_out;
        job.run_post     = run_post_out;
        job.edit         = edit_out;
    end

    assign job_push = accept && (has_lead || has_del_base || last_column);

    always_comb begin
        match_run_next  = match_run_reg;
        edit_count_next = edit_count_reg;
        if (accept) begin
            match_run_next  = last_column ? '0 : run_mid;
            edit_count_next = last_column ? '0 : edit_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_run_reg  <= '0;
            edit_count_reg <= '0;
        end else begin
            match_run_reg  <= match_run_next;
            edit_count_reg <= edit_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/amte_queue.sv =====
`default_nettype none

module amte_queue #(
    parameter int DEPTH = amte_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  amte_pkg::job_t      push_job,
    input  wire logic           pop,
    output amte_pkg::job_t      head_job,
    output logic                empty,
    output logic                full
);
    import amte_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    job_t           entries_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign empty    = count_reg == '0;
    assign full     = count_reg == CW'(DEPTH);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/amte_back.sv =====
`default_nettype none

module amte_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  amte_pkg::job_t             head_job,
    input  wire logic                  empty,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [amte_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);
    import amte_pkg::*;

    logic [2:0]             done_reg, done_next;
    logic [2:0]             pending, pick, rest;
    logic                   valid_reg, valid_next;
    logic                   slot_free, load;
    token_kind_t            kind_reg, kind_next;
    logic [OUT_WIDTH-1:0]   run_reg, run_next;
    logic [1:0]             base_reg, base_next;
    logic [OUT_WIDTH-1:0]   edit_reg;
    logic                   last_reg, eor_reg;

    assign pending   = {head_job.has_close, head_job.has_del_base, head_job.has_lead} & ~done_reg;
    assign pick      = pending & (~pending + 1'b1);
    assign rest      = pending & ~pick;
    assign slot_free = !valid_reg || m_tready;
    assign load      = slot_free && !empty;
    assign pop       = load && (rest == '0);

    always_comb begin
        kind_next = TOK_CLOSE_RUN;
        run_next  = head_job.run_post;
        base_next = 2'd0;
        priority if (pick[0]) begin
            kind_next = head_job.lead_is_del ? TOK_DEL_START : TOK_MISMATCH;
            run_next  = head_job.run_pre;
            base_next = head_job.lead_is_del ? 2'd0 : head_job.base;
        end else if (pick[1]) begin
            kind_next = TOK_DEL_BASE;
            base_next = head_job.base;
        end
    end

    always_comb begin
        done_next  = done_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            done_next  = pop ? '0 : (done_reg | pick);
        end else if (slot_free) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= kind_next;
            run_reg  <= run_next;
            base_reg <= base_next;
            edit_reg <= head_job.edit;
            last_reg <= rest == '0;
            eor_reg  <= pick[2];
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, edit_reg, base_reg, run_reg, kind_reg};
    assign m_tuser  = last_reg;
    assign m_tlast  = eor_reg;

endmodule

`default_nettype wire

// ===== src/alignment_mismatch_tag_encoder_top.sv =====
`default_nettype none

// Mismatch tag encoder: each input item is one alignment column, and the block
// answers with zero to three tokens (mismatch, deletion start, deleted base,
// closing run) carrying the saturating match run and edit distance. The front
// end takes one column per cycle, stalling only when the queue is full, and
// updates both counters at once; tokens wait in a queue of QUEUE_DEPTH items
// and leave through a registered output stage at one token per cycle while
// m_tready is high, and a column stays queued until its last token is loaded.
module alignment_mismatch_tag_encoder_top #(
    parameter int COUNT_WIDTH = amte_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = amte_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // column_kind[1:0], first_of_op[2], ref_base[4:3], read_base[7:5],
    // inside_reference[8], zero fill above.
    input  wire logic [amte_pkg::S_TDATA_WIDTH-1:0]    s_tdata,
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // token_kind[1:0], run_length[17:2], base[19:18], edit_distance[35:20],
    // zero fill above.
    output logic [amte_pkg::M_TDATA_WIDTH-1:0]         m_tdata,
    // last_result[0].
    output logic                                       m_tuser,
    output logic                                       m_tlast
);
    import amte_pkg::*;

    job_t   job, head_job;
    logic   job_push, pop, empty, full, accept;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    amte_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .column_kind      (s_tdata[1:0]),
        .first_of_op      (s_tdata[2]),
        .ref_base         (s_tdata[4:3]),
        .read_base        (s_tdata[7:5]),
        .inside_reference (s_tdata[8]),
        .last_column      (s_tlast),
        .job              (job),
        .job_push         (job_push)
    );

    amte_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    amte_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
